// ===== hdl/arpc_pkg.sv =====
// Package: shared widths, codes and control structs for the ARP cache table.
package arpc_pkg;

  localparam int unsigned ENTRIES_DEF = 128;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned AGE_W       = 16;

  localparam logic [AGE_W-1:0] AGE_MAX     = '1;
  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd15;

  typedef enum logic [OP_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } ctrl_state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch the item, rewind the scan
    logic issue;     // read the entry at the scan index, advance
    logic load_out;  // move the finished result into the output register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_idx;  // scan index sits on the final entry
    logic out_free;  // output register empty or being drained this cycle
  } dp_stat_t;

endpackage

// ===== hdl/arpc_req_if.sv =====
// Interface: request channel (operation, IP, MAC) with valid/ready.
interface arpc_req_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IP_W-1:0]  ip_address;
  logic [MAC_W-1:0] mac_address;

  modport source (output valid, operation, ip_address, mac_address, input ready);
  modport sink   (input valid, operation, ip_address, mac_address, output ready);

endinterface

// ===== hdl/arpc_rsp_if.sv =====
// Interface: response channel (lookup and insert results) with valid/ready.
interface arpc_rsp_if;
  import arpc_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic [MAC_W-1:0] found_mac;
  logic [AGE_W-1:0] found_age;
  logic             stored;
  logic             table_full;

  modport source (output valid, hit, found_mac, found_age, stored, table_full,
                  input ready);
  modport sink   (input valid, hit, found_mac, found_age, stored, table_full,
                  output ready);

endinterface

// ===== hdl/arpc_ctrl.sv =====
// Controller: sequences one request through the entry scan and the result hand-off.
module arpc_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  arpc_pkg::dp_stat_t   stat_i,
  output arpc_pkg::ctrl_cmd_t  cmd_o
);
  import arpc_pkg::*;

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.last_idx) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    req_ready_o    = 1'b0;
    cmd_o          = '0;
    case (state_q)
      ST_IDLE: begin
        req_ready_o = 1'b1;
        cmd_o.start = req_valid_i;
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
        // last entry is evaluated in the datapath this cycle
      end
      ST_FIN: begin
        cmd_o.load_out = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hdl/arpc_dp.sv =====
// Datapath: entry memories, valid bits, scan pipeline, result and output register.
module arpc_dp #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  arpc_pkg::ctrl_cmd_t          cmd_i,
  output arpc_pkg::dp_stat_t           stat_o,
  input  logic [arpc_pkg::OP_W-1:0]    op_i,
  input  logic [arpc_pkg::IP_W-1:0]    ip_i,
  input  logic [arpc_pkg::MAC_W-1:0]   mac_i,
  input  logic                         cfg_we_i,
  input  logic [arpc_pkg::AGE_W-1:0]   cfg_wdata_i,
  input  logic                         rsp_ready_i,
  output logic                         rsp_valid_o,
  output logic                         hit_o,
  output logic [arpc_pkg::MAC_W-1:0]   found_mac_o,
  output logic [arpc_pkg::AGE_W-1:0]   found_age_o,
  output logic                         stored_o,
  output logic                         table_full_o
);
  import arpc_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  // request and config registers
  op_e              op_q;
  logic [IP_W-1:0]  ip_q;
  logic [MAC_W-1:0] mac_q;
  logic [AGE_W-1:0] timeout_q;

  // scan index and evaluate stage
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] p_idx_q;
  logic             p_vld_q;

  // entry storage
  logic [ENTRIES-1:0] valid_q;
  logic [IP_W-1:0]    ip_mem  [ENTRIES];
  logic [MAC_W-1:0]   mac_mem [ENTRIES];
  logic [AGE_W-1:0]   age_mem [ENTRIES];
  logic [IP_W-1:0]    rd_ip_q;
  logic [MAC_W-1:0]   rd_mac_q;
  logic [AGE_W-1:0]   rd_age_q;

  // result accumulation
  logic             hit_q;
  logic [MAC_W-1:0] fmac_q;
  logic [AGE_W-1:0] fage_q;
  logic             found_q;

  // output register
  logic             out_vld_q;
  logic             out_hit_q;
  logic [MAC_W-1:0] out_mac_q;
  logic [AGE_W-1:0] out_age_q;
  logic             out_stored_q;
  logic             out_full_q;

  // evaluate-stage decode
  logic             ent_vld;
  logic             match;
  logic             ins;
  logic             tick_we;
  logic             expire;
  logic [AGE_W-1:0] age_inc;
  logic             age_we;
  logic [AGE_W-1:0] age_wdata;

  // timeout register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  // request latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= op_e'(op_i);
      ip_q  <= ip_i;
      mac_q <= mac_i;
    end
  end

  // scan index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      p_vld_q <= 1'b0;
    end else begin
      p_vld_q <= cmd_i.issue;
      if (cmd_i.start) begin
        idx_q <= '0;
      end else if (cmd_i.issue) begin
        idx_q <= idx_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) p_idx_q <= idx_q;
  end

  assign stat_o.last_idx = (idx_q == IDX_W'(ENTRIES - 1));
  assign stat_o.out_free = !out_vld_q || rsp_ready_i;

  // entry memories: registered read at the scan index, write at the evaluated index
  always_ff @(posedge clk_i) begin
    if (ins) ip_mem[p_idx_q] <= ip_q;
    if (cmd_i.issue) rd_ip_q <= ip_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (ins) mac_mem[p_idx_q] <= mac_q;
    if (cmd_i.issue) rd_mac_q <= mac_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (age_we) age_mem[p_idx_q] <= age_wdata;
    if (cmd_i.issue) rd_age_q <= age_mem[idx_q];
  end

  // evaluate one entry per cycle
  assign ent_vld = valid_q[p_idx_q];
  assign age_inc = (rd_age_q == AGE_MAX) ? rd_age_q : rd_age_q + AGE_W'(1);

  always_comb begin
    match   = 1'b0;
    ins     = 1'b0;
    tick_we = 1'b0;
    expire  = 1'b0;
    case (op_q)
      OP_LOOKUP: begin
        match = p_vld_q && ent_vld && (rd_ip_q == ip_q);
      end
      OP_INSERT: begin
        ins = p_vld_q && !ent_vld && !found_q;
      end
      OP_TICK: begin
        tick_we = p_vld_q && ent_vld;
        expire  = tick_we && (age_inc > timeout_q);
      end
      default: begin
      end
    endcase
  end

  assign age_we    = ins || tick_we;
  assign age_wdata = ins ? '0 : age_inc;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (ins) begin
      valid_q[p_idx_q] <= 1'b1;
    end else if (expire) begin
      valid_q[p_idx_q] <= 1'b0;
    end
  end

  // result accumulation; later matches override, giving the highest index
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      hit_q   <= 1'b0;
      fmac_q  <= '0;
      fage_q  <= '0;
      found_q <= 1'b0;
    end else begin
      if (match) begin
        hit_q  <= 1'b1;
        fmac_q <= rd_mac_q;
        fage_q <= rd_age_q;
      end
      if (ins) found_q <= 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_vld_q <= 1'b1;
    end else if (rsp_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_hit_q    <= hit_q;
      out_mac_q    <= fmac_q;
      out_age_q    <= fage_q;
      out_stored_q <= found_q;
      out_full_q   <= (op_q == OP_INSERT) && !found_q;
    end
  end

  assign rsp_valid_o  = out_vld_q;
  assign hit_o        = out_hit_q;
  assign found_mac_o  = out_mac_q;
  assign found_age_o  = out_age_q;
  assign stored_o     = out_stored_q;
  assign table_full_o = out_full_q;

`ifndef SYNTH
  // a result is only loaded when the output register can take it
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> stat_o.out_free)
    else $error("result loaded over a pending transfer");

  // an insert claims at most one slot
  a_single_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins |-> !found_q)
    else $error("insert wrote a second slot");

  // the evaluate stage only runs on entries the controller issued
  a_eval_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p_vld_q |-> $past(cmd_i.issue))
    else $error("entry evaluated without a read");

  // stored and full are never reported together
  a_stored_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_stored_q && out_full_q))
    else $error("stored and table_full both set");
`endif

endmodule

// ===== hdl/arp_cache_table_top.sv =====
// Top level: ARP cache table with lookup, insert and aging tick.
//
// Usage:
//   req_i carries one operation per transfer: lookup (0), insert (1),
//   aging tick (2) or no operation (3), with an IPv4 and a MAC address.
//   rsp_o returns exactly one result per request: hit, found_mac and
//   found_age for lookups, stored or table_full for inserts, all zero else.
//   cfg_we_i / cfg_wdata_i write the entry timeout in ticks (reset value 15);
//   write it only while no request is in flight.
// Timing:
//   Every operation walks all ENTRIES slots through one registered memory
//   read port, one slot per cycle. An accepted request is latched, its slots
//   are read in the scan state, the last is evaluated in the drain state and
//   the finish state loads the output register; the next request waits for it.
// Reset:
//   All valid bits clear at once; address and age memories are left as is.
// Stall:
//   The result sits in an output register; the scan of the next request runs
//   while it waits, and that request is held at its end until rsp_o drains.
module arp_cache_table_top #(
  parameter int unsigned ENTRIES = arpc_pkg::ENTRIES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  arpc_req_if.sink                    req_i,
  arpc_rsp_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [arpc_pkg::AGE_W-1:0]  cfg_wdata_i
);
  import arpc_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer
  arpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // table storage and result path
  arpc_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .op_i         (req_i.operation),
    .ip_i         (req_i.ip_address),
    .mac_i        (req_i.mac_address),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_valid_o  (rsp_o.valid),
    .hit_o        (rsp_o.hit),
    .found_mac_o  (rsp_o.found_mac),
    .found_age_o  (rsp_o.found_age),
    .stored_o     (rsp_o.stored),
    .table_full_o (rsp_o.table_full)
  );

endmodule
